### rtl/core/first_fit_heap_allocator_assert.svh
// Assertion macros used by the heap allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ffha_pkg.sv
// Package with types, codes and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_WORDS_DEF = 4096;

  localparam int HDR_W  = 32;
  localparam int LEN_W  = 30;
  localparam int NEED_W = 14;
  localparam int SIZE_W = 15;
  localparam int ADDR_W = 12;
  localparam int CNT_W  = 13;

  localparam logic [1:0] KIND_FREE = 2'b01;
  localparam logic [1:0] KIND_USED = 2'b10;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_CORRUPT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_EVAL,
    S_SPLIT,
    S_NRD,
    S_NEV,
    S_MERGE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_succ;
    logic    take_whole;
    logic    split_hdr;
    logic    split_tail;
    logic    advance;
    logic    latch_hit;
    logic    absorb_succ;
    logic    merge_write;
    logic    set_status;
    logic    emit;
    status_t code;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic pos_oob;
    logic hdr_bad;
    logic is_alloc;
    logic fit_whole;
    logic fit_split;
    logic hit;
    logic hit_used;
    logic succ_in;
    logic succ_free;
    logic succ_bad;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: controller plus datapath.
//
//  channel | dir | fields (low bit up)                              | handshake
//  in_     | in  | tuser: func; tdata: size_bytes, block_addr       | tvalid/tready
//  out_    | out | tdata: result_addr, status, block_count          | tvalid/tready
//
// Each item walks the headers from word 0, each header read through the registered heap RAM
// port (S_WALK) and then evaluated (S_EVAL); a walk past the last block ends the item, a split
// adds the S_SPLIT state, a free of a used block adds S_MERGE, and before it S_NRD and S_NEV
// when it reads the successor header. After reset the heap word 0 reads as one free
// block over the whole heap; there is no clearing pass. A stalled result holds its register;
// the next item is taken while it waits and its own result waits until the register frees.
module first_fit_heap_allocator #(
  parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // size_bytes [14:0], block_addr [26:15]
  input  logic        in_tuser,   // func [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result_addr [11:0], status [13:12], block_count [26:14]
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffha_dpath #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/ffha_ram.sv
// Generic simple dual-port RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/ffha_ctrl.sv
// Controller state machine that sequences the heap walk of each request.
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t  cmd
);

  ffha_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ffha_pkg::S_WALK;
      end
      ffha_pkg::S_WALK: begin
        if (stat.walk_done || stat.pos_oob) state_nxt = ffha_pkg::S_DONE;
        else state_nxt = ffha_pkg::S_EVAL;
      end
      ffha_pkg::S_EVAL: begin
        if (stat.hdr_bad) begin
          state_nxt = ffha_pkg::S_DONE;
        end else if (stat.is_alloc) begin
          if (stat.fit_whole) state_nxt = ffha_pkg::S_DONE;
          else if (stat.fit_split) state_nxt = ffha_pkg::S_SPLIT;
          else state_nxt = ffha_pkg::S_WALK;
        end else if (stat.hit) begin
          if (!stat.hit_used) state_nxt = ffha_pkg::S_DONE;
          else if (stat.succ_in) state_nxt = ffha_pkg::S_NRD;
          else state_nxt = ffha_pkg::S_MERGE;
        end else begin
          state_nxt = ffha_pkg::S_WALK;
        end
      end
      ffha_pkg::S_SPLIT: state_nxt = ffha_pkg::S_DONE;
      ffha_pkg::S_NRD:   state_nxt = ffha_pkg::S_NEV;
      ffha_pkg::S_NEV: begin
        if (stat.succ_free && stat.succ_bad) state_nxt = ffha_pkg::S_DONE;
        else state_nxt = ffha_pkg::S_MERGE;
      end
      ffha_pkg::S_MERGE: state_nxt = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = ffha_pkg::S_IDLE;
      end
      default: state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.code  = ffha_pkg::STAT_OK;
    in_tready = 1'b0;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ffha_pkg::S_WALK: begin
        if (stat.walk_done) begin
          cmd.set_status = 1'b1;
          cmd.code = stat.is_alloc ? ffha_pkg::STAT_OOM : ffha_pkg::STAT_INVALID;
        end else if (stat.pos_oob) begin
          cmd.set_status = 1'b1;
          cmd.code = ffha_pkg::STAT_CORRUPT;
        end
      end
      ffha_pkg::S_EVAL: begin
        if (stat.hdr_bad) begin
          cmd.set_status = 1'b1;
          cmd.code = ffha_pkg::STAT_CORRUPT;
        end else if (stat.is_alloc) begin
          if (stat.fit_whole) begin
            cmd.take_whole = 1'b1;
            cmd.set_status = 1'b1;
          end else if (stat.fit_split) begin
            cmd.split_hdr = 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (stat.hit) begin
          if (!stat.hit_used) begin
            // Double free and free of a block that was never handed out.
            cmd.set_status = 1'b1;
            cmd.code = ffha_pkg::STAT_INVALID;
          end else begin
            cmd.latch_hit = 1'b1;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ffha_pkg::S_SPLIT: begin
        cmd.split_tail = 1'b1;
        cmd.set_status = 1'b1;
      end
      ffha_pkg::S_NRD: cmd.rd_succ = 1'b1;
      ffha_pkg::S_NEV: begin
        if (stat.succ_free) begin
          if (stat.succ_bad) begin
            cmd.set_status = 1'b1;
            cmd.code = ffha_pkg::STAT_CORRUPT;
          end else begin
            cmd.absorb_succ = 1'b1;
          end
        end
      end
      ffha_pkg::S_MERGE: begin
        cmd.merge_write = 1'b1;
        cmd.set_status = 1'b1;
      end
      ffha_pkg::S_DONE: cmd.emit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/core/ffha_dpath.sv
// Datapath: heap memory, walk registers, header decode and result register.
module ffha_dpath #(
  parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     in_tdata,
  input  logic            in_tuser,
  input  ffha_pkg::cmd_t  cmd,
  output ffha_pkg::stat_t stat,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int PW = AW + 1;
  localparam int BW = $clog2(HEAP_WORDS + 1);
  localparam int SW = ffha_pkg::LEN_W + 1;
  localparam int LW = ffha_pkg::LEN_W;
  localparam int NW = ffha_pkg::NEED_W;
  localparam logic [ffha_pkg::HDR_W-1:0] RESET_WORD =
    {ffha_pkg::KIND_FREE, LW'(HEAP_WORDS - 1)};

  logic                    func_r, func_nxt;
  logic [NW-1:0]           need_r, need_nxt;
  logic [ffha_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [BW-1:0]           remain_r, remain_nxt;
  logic [BW-1:0]           blocks_r, blocks_nxt;
  logic                    prev_free_r, prev_free_nxt;
  logic [AW-1:0]           prev_pos_r, prev_pos_nxt;
  logic [LW-1:0]           prev_len_r, prev_len_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic [AW-1:0]           hpos_r, hpos_nxt;
  logic [PW-1:0]           succ_r, succ_nxt;
  logic [SW-1:0]           newlen_r, newlen_nxt;
  logic                    drop_r, drop_nxt;
  logic [ffha_pkg::ADDR_W-1:0] res_r, res_nxt;
  ffha_pkg::status_t       status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [31:0]             out_data_r, out_data_nxt;
  logic                    w0_valid_r, w0_valid_nxt;
  logic                    rd_zero_r;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [ffha_pkg::HDR_W-1:0]  wr_data, rd_data, hdr;
  logic [1:0]                  hdr_kind;
  logic [LW-1:0]               hdr_len, need_x;
  logic [SW-1:0]               end_sum, succ_end, final_len;
  logic                        kind_free, kind_used;

  ffha_ram #(
    .WIDTH (ffha_pkg::HDR_W),
    .DEPTH (HEAP_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Word 0 holds the initial free header until the first write reaches it.
  assign hdr       = (rd_zero_r && !w0_valid_r) ? RESET_WORD : rd_data;
  assign hdr_kind  = hdr[ffha_pkg::HDR_W-1 -: 2];
  assign hdr_len   = hdr[LW-1:0];
  assign kind_free = (hdr_kind == ffha_pkg::KIND_FREE);
  assign kind_used = (hdr_kind == ffha_pkg::KIND_USED);
  assign need_x    = LW'(need_r);
  assign end_sum   = SW'(pos_r) + SW'(hdr_len) + SW'(1);
  assign succ_end  = SW'(succ_r) + SW'(hdr_len) + SW'(1);
  assign final_len = newlen_r + (prev_free_r ? (SW'(prev_len_r) + SW'(1)) : SW'(0));
  assign rd_addr   = cmd.rd_succ ? succ_r[AW-1:0] : pos_r[AW-1:0];

  always_comb begin
    stat.walk_done = (remain_r == '0);
    stat.pos_oob   = (SW'(pos_r) >= SW'(HEAP_WORDS));
    stat.hdr_bad   = !(kind_free || kind_used) || (end_sum > SW'(HEAP_WORDS));
    stat.is_alloc  = (func_r == ffha_pkg::FUNC_ALLOC);
    stat.fit_whole = kind_free && ((hdr_len == need_x) || (hdr_len == need_x + LW'(1)));
    stat.fit_split = kind_free && (hdr_len > need_x + LW'(1));
    stat.hit       = ((32'(pos_r) + 32'd1) == 32'(addr_r));
    stat.hit_used  = kind_used;
    stat.succ_in   = (end_sum < SW'(HEAP_WORDS));
    stat.succ_free = kind_free;
    stat.succ_bad  = (succ_end > SW'(HEAP_WORDS));
    stat.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r[AW-1:0];
    wr_data = '0;
    if (cmd.take_whole) begin
      wr_en   = 1'b1;
      wr_data = {ffha_pkg::KIND_USED, hdr_len};
    end else if (cmd.split_hdr) begin
      wr_en   = 1'b1;
      wr_data = {ffha_pkg::KIND_USED, need_x};
    end else if (cmd.split_tail) begin
      wr_en   = 1'b1;
      wr_addr = AW'(SW'(pos_r) + SW'(need_r) + SW'(1));
      wr_data = {ffha_pkg::KIND_FREE, len_r - need_x - LW'(1)};
    end else if (cmd.merge_write) begin
      wr_en   = 1'b1;
      wr_addr = prev_free_r ? prev_pos_r : hpos_r;
      wr_data = {ffha_pkg::KIND_FREE, final_len[LW-1:0]};
    end
  end

  always_comb begin
    func_nxt      = func_r;
    need_nxt      = need_r;
    addr_nxt      = addr_r;
    pos_nxt       = pos_r;
    remain_nxt    = remain_r;
    blocks_nxt    = blocks_r;
    prev_free_nxt = prev_free_r;
    prev_pos_nxt  = prev_pos_r;
    prev_len_nxt  = prev_len_r;
    len_nxt       = len_r;
    hpos_nxt      = hpos_r;
    succ_nxt      = succ_r;
    newlen_nxt    = newlen_r;
    drop_nxt      = drop_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    w0_valid_nxt  = w0_valid_r || (wr_en && (wr_addr == '0));

    if (cmd.load) begin
      func_nxt      = in_tuser;
      need_nxt      = NW'((17'(in_tdata[ffha_pkg::SIZE_W-1:0]) + 17'd3) >> 2);
      addr_nxt      = in_tdata[ffha_pkg::SIZE_W +: ffha_pkg::ADDR_W];
      pos_nxt       = '0;
      remain_nxt    = blocks_r;
      prev_free_nxt = 1'b0;
      res_nxt       = '0;
    end
    if (cmd.advance) begin
      prev_free_nxt = kind_free;
      prev_pos_nxt  = pos_r[AW-1:0];
      prev_len_nxt  = hdr_len;
      pos_nxt       = PW'(end_sum);
      remain_nxt    = remain_r - BW'(1);
    end
    if (cmd.take_whole || cmd.split_hdr) begin
      res_nxt = ffha_pkg::ADDR_W'(pos_r + PW'(1));
    end
    if (cmd.split_hdr) begin
      len_nxt = hdr_len;
    end
    if (cmd.split_tail) begin
      blocks_nxt = blocks_r + BW'(1);
    end
    if (cmd.latch_hit) begin
      hpos_nxt   = pos_r[AW-1:0];
      succ_nxt   = PW'(end_sum);
      newlen_nxt = SW'(hdr_len);
      drop_nxt   = 1'b0;
    end
    if (cmd.absorb_succ) begin
      newlen_nxt = newlen_r + SW'(hdr_len) + SW'(1);
      drop_nxt   = 1'b1;
    end
    if (cmd.merge_write) begin
      blocks_nxt = blocks_r - BW'(drop_r) - BW'(prev_free_r);
    end
    if (cmd.set_status) begin
      status_nxt = cmd.code;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = 32'({ffha_pkg::CNT_W'(blocks_r), status_r, res_r});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r    <= BW'(1);
      out_valid_r <= 1'b0;
      w0_valid_r  <= 1'b0;
    end else begin
      blocks_r    <= blocks_nxt;
      out_valid_r <= out_valid_nxt;
      w0_valid_r  <= w0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    need_r      <= need_nxt;
    addr_r      <= addr_nxt;
    pos_r       <= pos_nxt;
    remain_r    <= remain_nxt;
    prev_free_r <= prev_free_nxt;
    prev_pos_r  <= prev_pos_nxt;
    prev_len_r  <= prev_len_nxt;
    len_r       <= len_nxt;
    hpos_r      <= hpos_nxt;
    succ_r      <= succ_nxt;
    newlen_r    <= newlen_nxt;
    drop_r      <= drop_nxt;
    res_r       <= res_nxt;
    status_r    <= status_nxt;
    out_data_r  <= out_data_nxt;
    rd_zero_r   <= (rd_addr == '0);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level.
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result keeps its valid and its payload.
  `FFHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // The block works on one item at a time.
  `FFHA_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted while busy")

  // A failed request reports address zero.
  `FFHA_ASSERT_NOW(a_fail_addr, clk, rst_n, out_tvalid && (out_tdata[13:12] != ffha_pkg::STAT_OK), out_tdata[11:0] == 12'd0, "failure with nonzero address")

  // A new result only comes while the input side is closed.
  `FFHA_ASSERT_NOW(a_result_src, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result without a request in flight")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/sv/tb_first_fit_heap_allocator.sv
// Self-checking testbench for the first-fit heap allocator with its own heap predictor.
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int HEAP_N = HEAP_WORDS_DEF;
  localparam int RANDOM_PER_PHASE = 256;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIVE_TARGET = 48;

  typedef struct packed {
    logic [11:0] addr;
    status_t     status;
    logic [12:0] count;
  } heap_reply_t;

  typedef struct packed {
    logic        func;
    logic [14:0] size;
    logic [11:0] addr;
    logic        typed;
    heap_reply_t reply;
  } script_row_t;

  localparam int SCRIPT_LEN = 27;
  // Columns: operation, size in bytes, payload address, typed, and the typed reply.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{FUNC_ALLOC, 15'd0,     12'd0,    1'b1, '{12'd1, STAT_OK, 13'd2}},
    '{FUNC_FREE,  15'd0,     12'd1,    1'b1, '{12'd0, STAT_OK, 13'd1}},
    '{FUNC_FREE,  15'd0,     12'd1,    1'b1, '{12'd0, STAT_INVALID, 13'd1}},
    '{FUNC_FREE,  15'd0,     12'd0,    1'b1, '{12'd0, STAT_INVALID, 13'd1}},
    '{FUNC_ALLOC, 15'd16384, 12'd0,    1'b1, '{12'd0, STAT_OOM, 13'd1}},
    '{FUNC_ALLOC, 15'd16380, 12'd0,    1'b1, '{12'd1, STAT_OK, 13'd1}},
    '{FUNC_ALLOC, 15'd1,     12'd0,    1'b1, '{12'd0, STAT_OOM, 13'd1}},
    '{FUNC_FREE,  15'd0,     12'd4095, 1'b1, '{12'd0, STAT_INVALID, 13'd1}},
    '{FUNC_FREE,  15'd0,     12'd1,    1'b1, '{12'd0, STAT_OK, 13'd1}},
    '{FUNC_ALLOC, 15'd4,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd5,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd3,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd3,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd1,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd16,    12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd6,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd1,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd8,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd8,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd8,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd1,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd7,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd4,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd4,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd0,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_FREE,  15'd0,     12'd1,    1'b0, '{12'd0, STAT_OK, 13'd0}},
    '{FUNC_ALLOC, 15'd0,     12'd0,    1'b0, '{12'd0, STAT_OK, 13'd0}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic [31:0]  heap_mem [HEAP_N];
  int unsigned  chain_blocks;
  heap_reply_t  pending_replies [$];
  logic [11:0]  live_payloads [$];
  logic [11:0]  freed_payloads [$];
  int           sender_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;

  first_fit_heap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // size_bytes [14:0], block_addr [26:15]
    .in_tuser   (in_tuser),   // func [0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // result_addr [11:0], status [13:12], block_count [26:14]
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void heap_reset();
    for (int i = 0; i < HEAP_N; i++) heap_mem[i] = '0;
    heap_mem[0] = {KIND_FREE, 30'(HEAP_N - 1)};
    chain_blocks = 1;
  endfunction

  function automatic status_t heap_alloc(input logic [14:0] sz, output logic [11:0] addr);
    int unsigned need, pos, remain, len;
    logic [1:0]  kind;
    need = (int'(sz) + 3) >> 2;
    pos = 0;
    remain = chain_blocks;
    addr = '0;
    while (remain != 0) begin
      if (pos >= HEAP_N) return STAT_CORRUPT;
      kind = heap_mem[pos][31:30];
      len = heap_mem[pos][29:0];
      if (kind != KIND_FREE && kind != KIND_USED) return STAT_CORRUPT;
      if (longint'(pos) + len + 1 > HEAP_N) return STAT_CORRUPT;
      if (kind == KIND_FREE) begin
        // A block one word too large is handed out whole, since the spare word
        // could not hold a header and a payload.
        if (len == need || len == need + 1) begin
          heap_mem[pos] = {KIND_USED, 30'(len)};
          addr = 12'(pos + 1);
          return STAT_OK;
        end
        if (len > need + 1) begin
          heap_mem[pos] = {KIND_USED, 30'(need)};
          heap_mem[pos + need + 1] = {KIND_FREE, 30'(len - need - 1)};
          chain_blocks++;
          addr = 12'(pos + 1);
          return STAT_OK;
        end
      end
      pos += len + 1;
      remain--;
    end
    return STAT_OOM;
  endfunction

  function automatic status_t heap_free(input logic [11:0] ad);
    int unsigned pos, remain, len, newlen, target, nxt, nl, drop, prev_pos, prev_len;
    logic [1:0]  kind;
    bit          prev_free;
    pos = 0;
    remain = chain_blocks;
    prev_free = 1'b0;
    prev_pos = 0;
    prev_len = 0;
    while (remain != 0) begin
      if (pos >= HEAP_N) return STAT_CORRUPT;
      kind = heap_mem[pos][31:30];
      len = heap_mem[pos][29:0];
      if (kind != KIND_FREE && kind != KIND_USED) return STAT_CORRUPT;
      if (longint'(pos) + len + 1 > HEAP_N) return STAT_CORRUPT;
      if (pos + 1 == ad) begin
        if (kind != KIND_USED) return STAT_INVALID;
        newlen = len;
        target = pos;
        nxt = pos + len + 1;
        drop = 0;
        if (nxt < HEAP_N && heap_mem[nxt][31:30] == KIND_FREE) begin
          nl = heap_mem[nxt][29:0];
          if (longint'(nxt) + nl + 1 > HEAP_N) return STAT_CORRUPT;
          newlen += nl + 1;
          drop++;
        end
        if (prev_free) begin
          newlen += prev_len + 1;
          target = prev_pos;
          drop++;
        end
        heap_mem[target] = {KIND_FREE, newlen[29:0]};
        chain_blocks -= drop;
        return STAT_OK;
      end
      prev_free = (kind == KIND_FREE);
      prev_pos = pos;
      prev_len = len;
      pos += len + 1;
      remain--;
    end
    return STAT_INVALID;
  endfunction

  function automatic heap_reply_t heap_predict(input logic f, input logic [14:0] sz,
                                               input logic [11:0] ad);
    heap_reply_t r;
    logic [11:0] got;
    r.addr = '0;
    if (f == FUNC_ALLOC) begin
      r.status = heap_alloc(sz, got);
      r.addr = got;
    end else begin
      r.status = heap_free(ad);
    end
    r.count = 13'(chain_blocks);
    return r;
  endfunction

  // Offers one item, waits for its handshake and records what it should return.
  task automatic issue_request(input logic f, input logic [14:0] sz, input logic [11:0] ad,
                               input logic typed, input heap_reply_t typed_reply);
    heap_reply_t want;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {5'd0, ad, sz};
    do @(posedge clk); while (!in_tready);
    want = heap_predict(f, sz, ad);
    pending_replies.push_back(typed ? typed_reply : want);
    if (want.status == STAT_OK) begin
      if (f == FUNC_ALLOC) begin
        live_payloads.push_back(want.addr);
      end else begin
        for (int i = 0; i < live_payloads.size(); i++) begin
          if (live_payloads[i] == ad) begin
            live_payloads.delete(i);
            break;
          end
        end
        freed_payloads.push_back(ad);
        if (freed_payloads.size() > 32) void'(freed_payloads.pop_front());
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : reply_check
    heap_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected item: result_addr %0d status %0d block_count %0d",
               out_tdata[11:0], out_tdata[13:12], out_tdata[26:14]);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[11:0] !== want.addr) begin
          $error("result_addr: expected %0d, actual %0d", want.addr, out_tdata[11:0]);
          mismatches++;
        end
        if (out_tdata[13:12] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[13:12]);
          mismatches++;
        end
        if (out_tdata[26:14] !== want.count) begin
          $error("block_count: expected %0d, actual %0d", want.count, out_tdata[26:14]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int          pick;
    int          sel;
    logic        f;
    logic [14:0] sz;
    logic [11:0] ad;
    heap_reply_t blank;
    blank = '0;
    heap_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      issue_request(SCRIPT[i].func, SCRIPT[i].size, SCRIPT[i].addr,
                    SCRIPT[i].typed, SCRIPT[i].reply);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 86;
          recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 86;
        end
        default: begin
          sender_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        sz = 15'($urandom_range(0, 16384));
        ad = 12'($urandom_range(0, 4095));
        if (pick < 8) begin
          // Bad pointers: arbitrary words, null, stale blocks and mid-payload words.
          f = FUNC_FREE;
          sel = $urandom_range(0, 3);
          if (sel == 1) ad = '0;
          else if (sel == 2 && freed_payloads.size() != 0)
            ad = freed_payloads[$urandom_range(0, freed_payloads.size() - 1)];
          else if (sel == 3 && live_payloads.size() != 0)
            ad = live_payloads[$urandom_range(0, live_payloads.size() - 1)] + 12'd1;
        end else if (live_payloads.size() != 0 &&
                     (pick < 45 || live_payloads.size() > LIVE_TARGET)) begin
          f = FUNC_FREE;
          ad = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
        end else begin
          f = FUNC_ALLOC;
          sel = $urandom_range(0, 99);
          if (sel < 10) sz = 15'($urandom_range(0, 3));
          else if (sel < 85) sz = 15'($urandom_range(0, 200));
          else if (sel < 97) sz = 15'($urandom_range(0, 2000));
        end
        issue_request(f, sz, ad, 1'b0, blank);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #25000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_ctrl.sv
rtl/core/ffha_dpath.sv
rtl/core/first_fit_heap_allocator.sv
rtl/core/ffha_checker.sv
tb/sv/tb_first_fit_heap_allocator.sv
